/* src/modexp_pkg.sv */
// ----------------------------------------------------------------------------
// modexp_pkg: shared constants and types for modular exponentiation
// Field widths, datapath widths and the operand bundle of the serial
// modular multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

   // field widths at the ports
   localparam int BASE_WIDTH    = 32;
   localparam int EXPF_WIDTH    = 32;
   localparam int RESULT_WIDTH  = 32;
   localparam int MODF_WIDTH    = 32;

   // datapath widths
   localparam int MOD_WIDTH     = 32;
   localparam int EXP_WIDTH     = 32;

   // serial multiplier scans this many bits of its b operand
   localparam int SCAN_WIDTH    = (MOD_WIDTH > BASE_WIDTH) ? MOD_WIDTH : BASE_WIDTH;
   localparam int CNT_WIDTH     = $clog2(SCAN_WIDTH);

   localparam logic [MODF_WIDTH-1:0] MODULUS_RESET = MODF_WIDTH'(23);

   // operands of one pass of the two-lane serial multiplier
   typedef struct packed {
      logic [MOD_WIDTH-1:0]  a0;
      logic [MOD_WIDTH-1:0]  a1;
      logic [SCAN_WIDTH-1:0] b;
   } mul_cmd_type;

endpackage

/* src/modexp_mulser.sv */
// ----------------------------------------------------------------------------
// modexp_mulser: two-lane bit-serial modular multiplier
// Computes a0*b mod m and a1*b mod m, one bit of b per cycle, msb first.
// A modulus of zero wraps at MOD_WIDTH bits.
// ----------------------------------------------------------------------------
module modexp_mulser
   import modexp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mul_cmd_type          cmd,
   input  logic [MOD_WIDTH-1:0] m,
   output logic                 done,
   output logic [MOD_WIDTH-1:0] r0,
   output logic [MOD_WIDTH-1:0] r1
);

   // r <- (2r + bit*a) mod m; with r < m and a <= m the sum stays below 3m
   function automatic logic [MOD_WIDTH-1:0] mod_step(
      input logic [MOD_WIDTH-1:0] r,
      input logic [MOD_WIDTH-1:0] a,
      input logic                 b_bit,
      input logic [MOD_WIDTH-1:0] mv
   );
      logic [MOD_WIDTH+1:0] sum;
      logic [MOD_WIDTH+1:0] m1;
      logic [MOD_WIDTH+1:0] m2;
      logic [MOD_WIDTH+1:0] d1;
      logic [MOD_WIDTH+1:0] d2;
      logic [MOD_WIDTH-1:0] res;
      sum = {1'b0, r, 1'b0} + (b_bit ? {2'b00, a} : '0);
      m1  = {2'b00, mv};
      m2  = {1'b0, mv, 1'b0};
      d1  = sum - m1;
      d2  = sum - m2;
      if (mv == '0) begin
         res = sum[MOD_WIDTH-1:0];
      end else if (sum >= m2) begin
         res = d2[MOD_WIDTH-1:0];
      end else if (sum >= m1) begin
         res = d1[MOD_WIDTH-1:0];
      end else begin
         res = sum[MOD_WIDTH-1:0];
      end
      return res;
   endfunction

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [MOD_WIDTH-1:0]  a0_ff, a0_in;
   logic [MOD_WIDTH-1:0]  a1_ff, a1_in;
   logic [SCAN_WIDTH-1:0] b_ff, b_in;
   logic [MOD_WIDTH-1:0]  r0_ff, r0_in;
   logic [MOD_WIDTH-1:0]  r1_ff, r1_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a0_in   = a0_ff;
      a1_in   = a1_ff;
      b_in    = b_ff;
      r0_in   = r0_ff;
      r1_in   = r1_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(SCAN_WIDTH - 1);
         a0_in   = cmd.a0;
         a1_in   = cmd.a1;
         b_in    = cmd.b;
         r0_in   = '0;
         r1_in   = '0;
      end else if (busy_ff) begin
         r0_in = mod_step(r0_ff, a0_ff, b_ff[SCAN_WIDTH-1], m);
         r1_in = mod_step(r1_ff, a1_ff, b_ff[SCAN_WIDTH-1], m);
         b_in  = {b_ff[SCAN_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a0_ff  <= a0_in;
      a1_ff  <= a1_in;
      b_ff   <= b_in;
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
   end

   assign done = done_ff;
   assign r0   = r0_ff;
   assign r1   = r1_ff;

endmodule

/* src/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation: base^exponent mod modulus
// Right-to-left square-and-multiply over a bit-serial modular multiplier.
//
//   channel  ports                          direction  carries
//   req      req_valid / req_stall          in         base value, exponent
//   rsp      rsp_valid / rsp_stall          out        power result
//   csr      csr_wr_en / csr_wr_data        in         modulus
//
// Each item reduces the base in one multiplier pass, then runs a launch step
// and one shared square/multiply pass per exponent bit up to the highest set
// bit, loads the output register and goes back to idle. An exponent of zero
// skips the multiplier and goes straight to the output register. One item is
// in work at a time; the output register frees the input side while a result
// waits under rsp_stall. Reset sets the modulus to 23 and empties the block.
// ----------------------------------------------------------------------------
module modular_exponentiation
   import modexp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [BASE_WIDTH-1:0]   req_base_value,
   input  logic [EXPF_WIDTH-1:0]   req_exponent,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [RESULT_WIDTH-1:0] rsp_power_result,
   input  logic                    csr_wr_en,
   input  logic [MODF_WIDTH-1:0]   csr_wr_data
);

   localparam int MW_MAX = (MOD_WIDTH > MODF_WIDTH) ? MOD_WIDTH : MODF_WIDTH;
   localparam int EW_MAX = (EXP_WIDTH > EXPF_WIDTH) ? EXP_WIDTH : EXPF_WIDTH;
   localparam int RW_MAX = (MOD_WIDTH > RESULT_WIDTH) ? MOD_WIDTH : RESULT_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_STEP,
      ST_MUL,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [MODF_WIDTH-1:0] modulus_ff, modulus_in;
   logic [EXP_WIDTH-1:0]  exp_ff, exp_in;
   logic [MOD_WIDTH-1:0]  result_ff, result_in;
   logic [MOD_WIDTH-1:0]  power_ff, power_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic [MW_MAX-1:0]     mod_ext;
   logic [MOD_WIDTH-1:0]  mod_val;
   logic [EW_MAX-1:0]     exp_ext;
   logic [EXP_WIDTH-1:0]  exp_val;
   logic [RW_MAX-1:0]     res_ext;
   logic                  accept;
   logic                  mul_start;
   mul_cmd_type           mul_cmd;
   logic                  mul_done;
   logic [MOD_WIDTH-1:0]  mul_r0;
   logic [MOD_WIDTH-1:0]  mul_r1;
   logic                  out_free;

   assign mod_ext = MW_MAX'(modulus_ff);
   assign mod_val = mod_ext[MOD_WIDTH-1:0];
   assign exp_ext = EW_MAX'(req_exponent);
   assign exp_val = exp_ext[EXP_WIDTH-1:0];
   assign res_ext = RW_MAX'(result_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // base pass multiplies the base by one; exponent passes square the power
   // in lane 1 and multiply it into the running result in lane 0
   always_comb begin
      mul_start = 1'b0;
      mul_cmd   = '{a0: result_ff, a1: power_ff, b: SCAN_WIDTH'(power_ff)};
      if (accept && exp_val != '0) begin
         mul_start = 1'b1;
         mul_cmd   = '{a0: MOD_WIDTH'(1), a1: MOD_WIDTH'(1),
                       b: SCAN_WIDTH'(req_base_value)};
      end else if (state_ff == ST_STEP) begin
         mul_start = 1'b1;
      end
   end

   modexp_mulser u_mulser (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .cmd   (mul_cmd),
      .m     (mod_val),
      .done  (mul_done),
      .r0    (mul_r0),
      .r1    (mul_r1)
   );

   always_comb begin
      state_in     = state_ff;
      modulus_in   = csr_wr_en ? csr_wr_data : modulus_ff;
      exp_in       = exp_ff;
      result_in    = result_ff;
      power_in     = power_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               exp_in    = exp_val;
               result_in = MOD_WIDTH'(1);
               state_in  = (exp_val == '0) ? ST_DONE : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               power_in = mul_r1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               if (exp_ff[0]) begin
                  result_in = mul_r0;
               end
               power_in = mul_r1;
               exp_in   = exp_ff >> 1;
               // stop once no set exponent bit remains
               state_in = ((exp_ff >> 1) == '0) ? ST_DONE : ST_STEP;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ext[RESULT_WIDTH-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff      <= exp_in;
      result_ff   <= result_in;
      power_ff    <= power_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

endmodule
